[rtl/core/u8d_pkg.sv]
// Shared types, constants and helpers for the UTF-8 code point decoder.
`default_nettype none

package u8d_pkg;

  localparam int BYTE_W = 8;
  localparam int CP_W   = 21;

  // Default depth of the command queue between front and back
  localparam int U8D_QUEUE_DEPTH = 2;

  localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;
  localparam logic [CP_W-1:0] MAX_CP         = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO        = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI        = 21'h00DFFF;
  localparam logic [CP_W-1:0] MIN_CP_2       = 21'h000080;
  localparam logic [CP_W-1:0] MIN_CP_3       = 21'h000800;
  localparam logic [CP_W-1:0] MIN_CP_4       = 21'h010000;

  // Sequence lengths held in the expected-bytes register
  localparam logic [2:0] SEQ_NONE = 3'd0;
  localparam logic [2:0] SEQ_LEN2 = 3'd2;
  localparam logic [2:0] SEQ_LEN3 = 3'd3;
  localparam logic [2:0] SEQ_LEN4 = 3'd4;

  typedef enum logic [2:0] {
    CLS_ZERO,
    CLS_ASCII,
    CLS_CONT,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_INVALID
  } byte_class_t;

  // One queued command: rep replacement results, then an optional tail result
  typedef struct packed {
    logic [1:0]      rep;
    logic            has_tail;
    logic [CP_W-1:0] tail_cp;
    logic            tail_eot;
  } cmd_t;

  function automatic byte_class_t classify(input logic [BYTE_W-1:0] b);
    byte_class_t cls;
    if (b == '0)                       cls = CLS_ZERO;
    else if (b[7] == 1'b0)             cls = CLS_ASCII;
    else if (b[7:6] == 2'b10)          cls = CLS_CONT;
    else if (b[7:5] == 3'b110)         cls = CLS_LEAD2;
    else if (b[7:4] == 4'b1110)        cls = CLS_LEAD3;
    else if (b[7:3] == 5'b11110)       cls = CLS_LEAD4;
    else                               cls = CLS_INVALID;
    return cls;
  endfunction

endpackage

`default_nettype wire

[rtl/core/u8d_if.sv]
// Valid/ready channel interfaces for the decoder's byte input and code point output.
`default_nettype none

interface u8d_in_if
  import u8d_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

interface u8d_out_if
  import u8d_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [CP_W-1:0] code_point;
  logic            end_of_text;
  logic            last;

  modport source (output valid, output code_point, output end_of_text, output last,
                  input ready);
  modport sink   (input valid, input code_point, input end_of_text, input last,
                  output ready);
endinterface

`default_nettype wire

[rtl/core/utf8_codepoint_decoder.sv]
// Top level of the UTF-8 code point decoder: front end, command queue, back end.
//
//   channel   dir  handshake      payload
//   in_bus    in   valid/ready    text_byte[7:0]
//   out_bus   out  valid/ready    code_point[20:0], end_of_text, last
//
// A byte is taken every cycle while the command queue has room; each byte that
// causes results queues one command; a byte gives up to four results. Unless the
// output stalls, the back end delivers one result per cycle, and sustained
// throughput is one byte per cycle when each gives at most one result.
// A stalled output fills the queue (QUEUE_DEPTH commands), then in_bus.ready drops.
// Synchronous active-low reset clears the pending sequence and empties the queue.
`default_nettype none

module utf8_codepoint_decoder
  import u8d_pkg::*;
#(
  parameter int QUEUE_DEPTH = U8D_QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  u8d_in_if.sink    in_bus,
  u8d_out_if.source out_bus
);

  logic push, pop, q_full, q_not_empty;
  cmd_t wr_cmd, head;

  u8d_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .q_full (q_full),
    .push   (push),
    .cmd    (wr_cmd)
  );

  u8d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_cmd    (wr_cmd),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head)
  );

  u8d_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_not_empty),
    .head       (head),
    .pop        (pop),
    .out_bus    (out_bus)
  );

endmodule

`default_nettype wire

[rtl/core/u8d_front.sv]
// Front end: accepts bytes, tracks the pending sequence and issues result commands.
`default_nettype none

module u8d_front
  import u8d_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  u8d_in_if.sink    in_bus,
  input  wire logic q_full,
  output logic      push,
  output cmd_t      cmd
);

  logic [CP_W-1:0] acc_r, acc_nxt;
  logic [2:0]      exp_r, exp_nxt;
  logic [1:0]      cs_r,  cs_nxt;

  byte_class_t     cls;
  logic            in_fire;
  logic [CP_W-1:0] acc_shift;
  logic [2:0]      cs_inc;
  logic [CP_W-1:0] min_cp;
  logic            bad;

  assign in_bus.ready = !q_full;
  assign in_fire      = in_bus.valid && in_bus.ready;
  assign cls          = classify(in_bus.text_byte);

  // Candidate value after taking one more continuation beat
  assign acc_shift = {acc_r[CP_W-7:0], in_bus.text_byte[5:0]};
  assign cs_inc    = {1'b0, cs_r} + 3'd1;

  always_comb begin
    case (exp_r)
      SEQ_LEN2: min_cp = MIN_CP_2;
      SEQ_LEN3: min_cp = MIN_CP_3;
      default:  min_cp = MIN_CP_4;
    endcase
  end

  assign bad = (acc_shift < min_cp) || (acc_shift > MAX_CP) ||
               ((acc_shift >= SURR_LO) && (acc_shift <= SURR_HI));

  // Sequence tracking and command build
  always_comb begin
    acc_nxt = acc_r;
    exp_nxt = exp_r;
    cs_nxt  = cs_r;
    cmd     = '0;

    if ((exp_r != SEQ_NONE) && (cls == CLS_CONT)) begin
      if ((cs_inc + 3'd1) >= exp_r) begin
        // sequence complete
        cmd.has_tail = 1'b1;
        cmd.tail_cp  = bad ? REPLACEMENT_CP : acc_shift;
        acc_nxt      = '0;
        exp_nxt      = SEQ_NONE;
        cs_nxt       = '0;
      end else begin
        acc_nxt = acc_shift;
        cs_nxt  = cs_inc[1:0];
      end
    end else begin
      // broken sequence: one replacement for the lead and each continuation taken
      if (exp_r != SEQ_NONE) begin
        cmd.rep = (cs_r == 2'd3) ? 2'd3 : cs_inc[1:0];
      end
      acc_nxt = '0;
      exp_nxt = SEQ_NONE;
      cs_nxt  = '0;

      // decode the byte afresh
      case (cls)
        CLS_ZERO: begin
          cmd.has_tail = 1'b1;
          cmd.tail_eot = 1'b1;
        end
        CLS_ASCII: begin
          cmd.has_tail = 1'b1;
          cmd.tail_cp  = {{(CP_W-BYTE_W){1'b0}}, in_bus.text_byte};
        end
        CLS_LEAD2: begin
          acc_nxt = {{(CP_W-5){1'b0}}, in_bus.text_byte[4:0]};
          exp_nxt = SEQ_LEN2;
        end
        CLS_LEAD3: begin
          acc_nxt = {{(CP_W-4){1'b0}}, in_bus.text_byte[3:0]};
          exp_nxt = SEQ_LEN3;
        end
        CLS_LEAD4: begin
          acc_nxt = {{(CP_W-3){1'b0}}, in_bus.text_byte[2:0]};
          exp_nxt = SEQ_LEN4;
        end
        default: begin
          cmd.has_tail = 1'b1;
          cmd.tail_cp  = REPLACEMENT_CP;
        end
      endcase
    end
  end

  assign push = in_fire && ((cmd.rep != 2'd0) || cmd.has_tail);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      exp_r <= SEQ_NONE;
      cs_r  <= '0;
    end else if (in_fire) begin
      acc_r <= acc_nxt;
      exp_r <= exp_nxt;
      cs_r  <= cs_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/u8d_queue.sv]
// Small register FIFO of result commands between front and back.
`default_nettype none

module u8d_queue
  import u8d_pkg::*;
#(
  parameter int DEPTH = U8D_QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  cmd_t      wr_cmd,
  input  wire logic pop,
  output logic      full,
  output logic      not_empty,
  output cmd_t      head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cmd_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full      = (count_r == FULL_CNT);
  assign not_empty = (count_r != '0);
  assign head      = slot_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/u8d_back.sv]
// Back end: expands each queued command into its result beats.
`default_nettype none

module u8d_back
  import u8d_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic head_valid,
  input  cmd_t      head,
  output logic      pop,
  u8d_out_if.source out_bus
);

  logic [1:0] idx_r, idx_nxt;
  logic [2:0] total;
  logic       is_last;
  logic       in_rep;
  logic       out_fire;

  assign total   = {1'b0, head.rep} + {2'b00, head.has_tail};
  assign is_last = ({1'b0, idx_r} == (total - 3'd1));
  assign in_rep  = (idx_r < head.rep);

  assign out_bus.valid       = head_valid;
  assign out_bus.code_point  = in_rep ? REPLACEMENT_CP : head.tail_cp;
  assign out_bus.end_of_text = in_rep ? 1'b0 : head.tail_eot;
  assign out_bus.last        = is_last;

  assign out_fire = out_bus.valid && out_bus.ready;
  assign pop      = out_fire && is_last;

  // Beat index within the current command
  always_comb begin
    idx_nxt = idx_r;
    if (out_fire) begin
      idx_nxt = is_last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

`default_nettype wire
